// ===== hdl/upss_pkg.sv =====
// upss_pkg: types and constants for the periodic split-transaction scheduler.
// No dependencies; imported by upss_core and usb_periodic_split_scheduler.
`timescale 1ns / 1ps

package upss_pkg;

	typedef enum logic [2:0] {
		PH_START_SPLIT = 3'd0,
		PH_START_DONE  = 3'd1,
		PH_COMP_SPLIT  = 3'd2,
		PH_COMP_RETRY  = 3'd3,
		PH_COMP_DONE   = 3'd4,
		PH_COMP_FAILED = 3'd5,
		PH_UNKNOWN     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_START_SPLIT = 2'd0,
		KIND_CSPLIT_QRY  = 2'd1,
		KIND_XFER_DONE   = 2'd2,
		KIND_FRAME_OBS   = 2'd3
	} kind_t;

	localparam int unsigned ST_XFER = 0;
	localparam int unsigned ST_ACK  = 1;
	localparam int unsigned ST_NYET = 2;
	localparam int unsigned ST_NAK  = 3;

	localparam logic [1:0] RETRIES_FULL  = 2'd3;
	localparam logic [1:0] RETRIES_SHORT = 2'd2;
	localparam logic [2:0] MF_SHORT      = 3'd5;
	localparam logic [2:0] MF_SKIP       = 3'd6;
	localparam logic [2:0] MF_AFTER_SKIP = 3'd7;
	localparam logic [2:0] MF_STEP_FIRST = 3'd2;
	localparam logic [2:0] MF_STEP_RETRY = 3'd1;
	localparam logic [3:0] DELAY_NONE    = 4'd0;
	localparam logic [3:0] DELAY_NAK     = 4'd5;
	localparam logic [3:0] DELAY_RETRY   = 4'd8;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] retries_left;
		logic [2:0] target_mf;
		logic       target_valid;
	} sched_state_t;

	typedef struct packed {
		logic       do_split;
		logic       frame_reached;
		logic       next_odd;
		logic [3:0] delay_frames;
		logic [2:0] phase_out;
		logic       error;
	} sched_result_t;

endpackage

// ===== hdl/upss_core.sv =====
// upss_core: next-state and result logic for one scheduler beat.
// Purely combinational; depends on upss_pkg.
`timescale 1ns / 1ps

module upss_core import upss_pkg::*; (
	input  sched_state_t  cur,
	input  kind_t         kind,
	input  logic [3:0]    status_bits,
	input  logic [2:0]    microframe,
	output sched_state_t  nxt,
	output sched_result_t res
);

	logic [2:0] tgt;
	logic [2:0] obs_next;

	assign tgt      = cur.target_valid ? cur.target_mf : 3'd0;
	assign obs_next = (microframe + 3'd1 == MF_SKIP) ? MF_AFTER_SKIP : microframe + 3'd1;

	always_comb begin
		nxt               = cur;
		res.do_split      = 1'b0;
		res.frame_reached = 1'b0;
		res.delay_frames  = DELAY_NONE;
		res.error         = 1'b0;

		case (kind)
			KIND_START_SPLIT: begin
				nxt.target_valid = 1'b0;
				nxt.phase        = PH_START_SPLIT;
			end
			KIND_CSPLIT_QRY: begin
				case (cur.phase)
					PH_START_DONE: begin
						nxt.phase        = PH_COMP_SPLIT;
						nxt.retries_left = (tgt == MF_SHORT) ? RETRIES_SHORT : RETRIES_FULL;
						nxt.target_mf    = tgt + MF_STEP_FIRST;
						nxt.target_valid = 1'b1;
						res.do_split     = 1'b1;
					end
					PH_COMP_RETRY: begin
						res.error        = ~cur.target_valid;
						nxt.target_mf    = tgt + MF_STEP_RETRY;
						nxt.target_valid = 1'b1;
						res.do_split     = 1'b1;
					end
					PH_COMP_DONE, PH_COMP_FAILED: ;
					default: res.error = 1'b1;
				endcase
			end
			KIND_XFER_DONE: begin
				case (cur.phase)
					PH_START_SPLIT: begin
						res.error = ~status_bits[ST_ACK];
						nxt.phase = PH_START_DONE;
					end
					PH_COMP_SPLIT, PH_COMP_RETRY: begin
						if (status_bits[ST_XFER]) begin
							nxt.phase = PH_COMP_DONE;
						end else if (status_bits[ST_NYET] || status_bits[ST_ACK]) begin
							if (cur.retries_left == 2'd0) begin
								nxt.phase        = PH_COMP_FAILED;
								res.delay_frames = DELAY_RETRY;
							end else begin
								nxt.retries_left = cur.retries_left - 2'd1;
								nxt.phase        = PH_COMP_RETRY;
							end
						end else if (status_bits[ST_NAK]) begin
							nxt.phase        = PH_COMP_FAILED;
							res.delay_frames = DELAY_NAK;
						end else begin
							res.error = 1'b1;
						end
					end
					default: res.error = 1'b1;
				endcase
			end
			default: begin
				if (!cur.target_valid) begin
					nxt.target_mf    = obs_next;
					nxt.target_valid = 1'b1;
				end
				res.frame_reached = (microframe == nxt.target_mf);
			end
		endcase

		res.next_odd  = nxt.target_valid & nxt.target_mf[0];
		res.phase_out = nxt.phase;
	end

endmodule

// ===== hdl/usb_periodic_split_scheduler.sv =====
// Periodic USB split-transaction scheduler, top level.
// A beat goes through the input register, then the result register. Throughput: one beat
// per cycle while out_ready does not stall the output, set by the combinational state
// update in upss_core. Reset clears the valid flags of both stages and puts the scheduler
// in the unknown phase with no target and no retries. Depends on upss_pkg and upss_core.
`timescale 1ns / 1ps

module usb_periodic_split_scheduler import upss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  status_bits,
	input  logic [13:0] frame_number,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        do_split,
	output logic        frame_reached,
	output logic        next_odd,
	output logic [3:0]  delay_frames,
	output logic [2:0]  phase_out,
	output logic        error
);

	logic          valid_s1;
	kind_t         kind_s1;
	logic [3:0]    status_s1;
	logic [2:0]    mf_s1;
	logic          advance;
	sched_state_t  state_q;
	sched_state_t  state_nxt;
	sched_result_t res_nxt;
	sched_result_t res_q;
	logic          out_valid_q;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1   <= kind_t'(kind);
			status_s1 <= status_bits;
			mf_s1     <= frame_number[2:0];
		end
	end

	upss_core u_core (
		.cur         (state_q),
		.kind        (kind_s1),
		.status_bits (status_s1),
		.microframe  (mf_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_UNKNOWN;
			state_q.retries_left <= 2'd0;
			state_q.target_mf    <= 3'd0;
			state_q.target_valid <= 1'b0;
			out_valid_q          <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign do_split      = res_q.do_split;
	assign frame_reached = res_q.frame_reached;
	assign next_odd      = res_q.next_odd;
	assign delay_frames  = res_q.delay_frames;
	assign phase_out     = res_q.phase_out;
	assign error         = res_q.error;

endmodule
